// ===== hw/rtl/hsfd_pkg.sv =====
// shared types, constants and the crc-8 step for the humidity sensor frame decoder
// no dependencies
package hsfd_pkg;

    localparam int unsigned FIFO_DEPTH = 4;

    localparam logic [7:0]  CRC_POLY = 8'h31;
    localparam logic [7:0]  CRC_INIT = 8'hFF;

    localparam logic [10:0] HEAT_OFFSET_RESET = 11'd400;

    localparam logic [30:0] TEMP_SPAN = 31'd17500;
    localparam logic [29:0] HUM_SPAN  = 30'd10000;
    localparam logic signed [15:0] TEMP_BASE = 16'sd4500;

    typedef struct packed {
        logic [15:0] temp_word;
        logic [15:0] humid_word;
        logic        crc_ok;
    } frame_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/hsfd_front.sv =====
// front end: takes one frame byte per accepted handshake, runs the crc and assembles the words
// depends on hsfd_pkg
module hsfd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          rx_byte,
    input  logic                frame_start,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                push,
    output hsfd_pkg::frame_t    push_frame,
    input  logic                queue_full
);

    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    logic [2:0]  pos_reg, pos_next, eff_pos;
    logic [7:0]  crc_reg, crc_next, crc_step, crc_base;
    logic        temp_good_reg, temp_good_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic [15:0] humid_word_reg, humid_word_next;
    logic        accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        eff_pos = (frame_start || pos_reg > POS_H_CRC) ? POS_T_HI : pos_reg;
        crc_base = (eff_pos == POS_T_HI || eff_pos == POS_H_HI) ? hsfd_pkg::CRC_INIT : crc_reg;
        crc_step = hsfd_pkg::crc8_byte(crc_base, rx_byte);

        crc_next        = crc_reg;
        temp_good_next  = temp_good_reg;
        temp_word_next  = temp_word_reg;
        humid_word_next = humid_word_reg;
        push            = 1'b0;

        unique case (eff_pos)
            POS_T_HI:
            begin
                crc_next       = crc_step;
                temp_word_next = {rx_byte, 8'h00};
            end
            POS_T_LO:
            begin
                crc_next       = crc_step;
                temp_word_next = {temp_word_reg[15:8], rx_byte};
            end
            POS_T_CRC:
            begin
                temp_good_next = (crc_reg == rx_byte);
                crc_next       = hsfd_pkg::CRC_INIT;
            end
            POS_H_HI:
            begin
                crc_next        = crc_step;
                humid_word_next = {rx_byte, 8'h00};
            end
            POS_H_LO:
            begin
                crc_next        = crc_step;
                humid_word_next = {humid_word_reg[15:8], rx_byte};
            end
            default:
            begin
                crc_next = hsfd_pkg::CRC_INIT;
                push     = accept;
            end
        endcase

        pos_next = (eff_pos >= POS_H_CRC) ? POS_T_HI : eff_pos + 3'd1;

        push_frame.temp_word  = temp_word_reg;
        push_frame.humid_word = humid_word_reg;
        push_frame.crc_ok     = temp_good_reg && (crc_reg == rx_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_T_HI;
            crc_reg       <= hsfd_pkg::CRC_INIT;
            temp_good_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            temp_good_reg <= temp_good_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            temp_word_reg  <= temp_word_next;
            humid_word_reg <= humid_word_next;
        end
    end

    pos_range_a: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_H_CRC)
        else $error("byte position out of range");

endmodule

// ===== hw/rtl/hsfd_fifo.sv =====
// short queue of finished frames between front and back end
// depends on hsfd_pkg
module hsfd_fifo #(
    parameter int unsigned DEPTH = hsfd_pkg::FIFO_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hsfd_pkg::frame_t  push_frame,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output hsfd_pkg::frame_t  head_frame
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    hsfd_pkg::frame_t  mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign not_empty  = (count_reg != '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && not_empty;
    assign head_frame = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_frame;
        end
    end

    count_bound_a: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    push_only_a: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");

    pop_only_a: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not follow a pop");

endmodule

// ===== hw/rtl/hsfd_back.sv =====
// back end: scales the words, keeps the last good values and holds the result word
// depends on hsfd_pkg
module hsfd_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     frame_valid,
    output logic                     frame_pop,
    input  hsfd_pkg::frame_t         frame,
    input  logic [10:0]              heat_offset,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [14:0]       temp_centi_c,
    output logic [13:0]              humidity_centi_pct,
    output logic                     crc_error,
    output logic                     have_value
);

    logic        s1_valid_reg;
    logic [30:0] s1_tprod_reg;
    logic [29:0] s1_hprod_reg;
    logic        s1_ok_reg;

    logic        s2_valid_reg;
    logic [14:0] s2_temp_reg;
    logic [13:0] s2_hum_reg;
    logic        s2_err_reg;
    logic        s2_have_reg;

    logic [14:0] last_temp_reg;
    logic [13:0] last_hum_reg;
    logic        present_reg;

    logic        s2_free, s1_free, s1_move;
    logic signed [15:0] t_full;
    logic [14:0] t_new;
    logic [13:0] h_new;

    assign s2_free   = !s2_valid_reg || out_ready;
    assign s1_move   = s1_valid_reg && s2_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign frame_pop = frame_valid && s1_free;

    assign t_full = $signed({1'b0, s1_tprod_reg[30:16]}) - hsfd_pkg::TEMP_BASE
                    - $signed({5'd0, heat_offset});
    assign t_new  = t_full[14:0];
    assign h_new  = s1_hprod_reg[29:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            last_temp_reg <= '0;
            last_hum_reg  <= '0;
            present_reg   <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= frame_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s1_move && s1_ok_reg)
            begin
                last_temp_reg <= t_new;
                last_hum_reg  <= h_new;
                present_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_pop)
        begin
            s1_tprod_reg <= hsfd_pkg::TEMP_SPAN * {15'd0, frame.temp_word};
            s1_hprod_reg <= hsfd_pkg::HUM_SPAN * {14'd0, frame.humid_word};
            s1_ok_reg    <= frame.crc_ok;
        end
        if (s1_move)
        begin
            s2_temp_reg <= s1_ok_reg ? t_new : last_temp_reg;
            s2_hum_reg  <= s1_ok_reg ? h_new : last_hum_reg;
            s2_err_reg  <= !s1_ok_reg;
            s2_have_reg <= s1_ok_reg || present_reg;
        end
    end

    assign out_valid          = s2_valid_reg;
    assign temp_centi_c       = $signed(s2_temp_reg);
    assign humidity_centi_pct = s2_hum_reg;
    assign crc_error          = s2_err_reg;
    assign have_value         = s2_have_reg;

    good_has_value_a: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_err_reg) |-> s2_have_reg)
        else $error("good word without have_value");

    present_sticky_a: assert property (@(posedge clk) disable iff (!rst_n)
        $past(present_reg) |-> present_reg)
        else $error("stored value flag cleared");

endmodule

// ===== hw/rtl/humidity_sensor_frame_decoder.sv =====
// top level of the humidity sensor frame decoder
// depends on hsfd_pkg, hsfd_front, hsfd_fifo, hsfd_back
//
// Takes the six bytes of a measurement frame (temperature word, crc, humidity
// word, crc) at one byte per cycle and gives one result word per frame: the
// last good temperature in 0.01 C and humidity in 0.01 %RH, a crc error flag
// and a flag that a good frame has been seen. The crc runs as one unrolled
// byte step per cycle in the front end; finished frames wait in a queue of
// FIFO_DEPTH entries, and the back end registers the two scaling multiplies
// and then the output word, which is held while out_ready is low. Byte input
// stalls only when the queue is full. The heat offset register is written
// directly and reset to 400.
module humidity_sensor_frame_decoder #(
    parameter int unsigned FIFO_DEPTH = hsfd_pkg::FIFO_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [10:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [14:0] temp_centi_c,
    output logic [13:0]        humidity_centi_pct,
    output logic               crc_error,
    output logic               have_value
);

    logic [10:0]       heat_offset_reg;
    logic              push, queue_full, pop, not_empty;
    hsfd_pkg::frame_t  push_frame, head_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heat_offset_reg <= hsfd_pkg::HEAT_OFFSET_RESET;
        end
        else if (cfg_wr_en)
        begin
            heat_offset_reg <= cfg_wr_data;
        end
    end

    hsfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (rx_byte),
        .frame_start(frame_start),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .push       (push),
        .push_frame (push_frame),
        .queue_full (queue_full)
    );

    hsfd_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_frame(push_frame),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_frame(head_frame)
    );

    hsfd_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .frame_valid       (not_empty),
        .frame_pop         (pop),
        .frame             (head_frame),
        .heat_offset       (heat_offset_reg),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .temp_centi_c      (temp_centi_c),
        .humidity_centi_pct(humidity_centi_pct),
        .crc_error         (crc_error),
        .have_value        (have_value)
    );

endmodule
